FILE: hdl/itaf_pkg.sv
// Shared types, constants and helpers for the integer to ASCII formatter.
`timescale 1ns / 1ps
`default_nettype none

package itaf_pkg;

    // Base select codes
    localparam logic [1:0] BASE_HEX = 2'd0;
    localparam logic [1:0] BASE_DEC = 2'd1;
    localparam logic [1:0] BASE_BIN = 2'd2;

    // Sign mode bits
    localparam int SIGN_PLUS_BIT  = 0;
    localparam int SIGN_MINUS_BIT = 1;

    // Fixed field widths
    localparam int NUM_W   = 32;
    localparam int WIDTH_W = 6;
    localparam int CHAR_W  = 8;

    // ASCII codes
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_SPACE   = 8'h20;
    localparam logic [7:0] ASCII_MINUS   = 8'h2D;
    localparam logic [7:0] ASCII_PLUS    = 8'h2B;
    localparam logic [3:0] DIGIT_TEN     = 4'hA;

    // Divide by ten as multiply by reciprocal, exact for any 32-bit dividend
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef enum logic [1:0] {
        CH_FILL,
        CH_SIGN,
        CH_DIGIT
    } t_char_sel;

    typedef struct packed {
        logic      load;
        logic      mul;
        logic      step;
        logic      prep;
        logic      emit;
        t_char_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic in_is_dec;
        logic is_dec;
        logic quo_zero;
        logic fill_done;
        logic has_sign;
        logic idx_zero;
        logic out_free;
    } t_dp_stat;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d <= 4'd9) begin
            return ASCII_ZERO + {4'd0, d};
        end
        return ASCII_LOWER_A + {4'd0, d} - {4'd0, DIGIT_TEN};
    endfunction

endpackage

`default_nettype wire

FILE: hdl/itaf_if.sv
// Valid/ready channel interfaces for number input and character output.
`timescale 1ns / 1ps
`default_nettype none

interface itaf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] number;
    logic [5:0]  min_width;
    logic [1:0]  base_select;
    logic        zero_fill;
    logic [1:0]  sign_mode;

    modport source (
        output valid, number, min_width, base_select, zero_fill, sign_mode,
        input  ready
    );
    modport sink (
        input  valid, number, min_width, base_select, zero_fill, sign_mode,
        output ready
    );
endinterface

interface itaf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_char;

    modport source (output valid, character, last_char, input ready);
    modport sink (input valid, character, last_char, output ready);
endinterface

`default_nettype wire

FILE: hdl/integer_to_ascii_formatter_unit.sv
// Top level of the integer to ASCII formatter.
//
// Usage:
//   i_in carries one number with its format per beat: min_width (capped at
//   MAX_FIELD_WIDTH), base_select (hex, decimal, binary; code 3 is hex),
//   zero_fill and sign_mode (minus wins over plus). o_out carries one ASCII
//   character per beat: fill, then the sign, then digits most significant
//   first, lowercase hex; last_char marks the final digit.
//   The number is taken modulo 2**min(NUMBER_BITS, 32).
// Timing:
//   One number at a time. i_in.ready is high only while the block is idle.
//   Digit extraction splits off one digit per step; in decimal each step is
//   a 32x32 reciprocal multiply, then remainder fix-up. Then a setup step,
//   the characters one by one, paused while the receiver stalls, and an
//   empty pass when the fill runs out. The first character waits for the
//   conversion and the setup step, and when there is no fill also for the
//   empty pass through the fill state.
// Reset and stall:
//   Synchronous active-low reset returns the sequencer to idle and clears the
//   output valid flag. A stalled receiver holds the current beat in the output
//   register and pauses emission; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter_unit #(
    parameter int NUMBER_BITS     = 32,
    parameter int MAX_FIELD_WIDTH = 63
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    itaf_in_if.sink     i_in,
    itaf_out_if.source  o_out
);
    import itaf_pkg::*;

    localparam int VAL_W = (NUMBER_BITS < NUM_W) ? NUMBER_BITS : NUM_W;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    itaf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    itaf_dp #(
        .VAL_W           (VAL_W),
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_number      (i_in.number),
        .i_min_width   (i_in.min_width),
        .i_base_select (i_in.base_select),
        .i_zero_fill   (i_in.zero_fill),
        .i_sign_mode   (i_in.sign_mode),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_character   (o_out.character),
        .o_last_char   (o_out.last_char),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

endmodule

`default_nettype wire

FILE: hdl/itaf_ctrl.sv
// Sequencer for digit extraction and character emission.
`timescale 1ns / 1ps
`default_nettype none

module itaf_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire itaf_pkg::t_dp_stat i_stat,
    output itaf_pkg::t_dp_cmd       o_cmd
);
    import itaf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIG,
        S_PREP,
        S_FILL,
        S_SIGN,
        S_DIGS
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;

    // Decode commands and next state
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.sel = CH_FILL;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = i_stat.in_is_dec ? S_MUL : S_DIG;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_DIG;
            end
            S_DIG: begin
                cmd.step = 1'b1;
                if (i_stat.quo_zero) begin
                    n_state = S_PREP;
                end else begin
                    n_state = i_stat.is_dec ? S_MUL : S_DIG;
                end
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                n_state  = S_FILL;
            end
            S_FILL: begin
                if (i_stat.fill_done) begin
                    n_state = i_stat.has_sign ? S_SIGN : S_DIGS;
                end else if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel  = CH_FILL;
                end
            end
            S_SIGN: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel  = CH_SIGN;
                    n_state  = S_DIGS;
                end
            end
            S_DIGS: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.sel  = CH_DIGIT;
                    if (i_stat.idx_zero) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

`default_nettype wire

FILE: hdl/itaf_dp.sv
// Datapath: value register, divide step, digit store, counters, output register.
`timescale 1ns / 1ps
`default_nettype none

module itaf_dp #(
    parameter int VAL_W           = 32,
    parameter int MAX_FIELD_WIDTH = 63
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [31:0]          i_number,
    input  wire logic [5:0]           i_min_width,
    input  wire logic [1:0]           i_base_select,
    input  wire logic                 i_zero_fill,
    input  wire logic [1:0]           i_sign_mode,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [7:0]                o_character,
    output logic                      o_last_char,
    input  wire itaf_pkg::t_dp_cmd    i_cmd,
    output itaf_pkg::t_dp_stat        o_stat
);
    import itaf_pkg::*;

    localparam int DIG_N = VAL_W;
    localparam int IDX_W = $clog2(DIG_N);
    localparam int ND_W  = $clog2(DIG_N + 1);

    logic [VAL_W-1:0]   r_val;
    logic [VAL_W-1:0]   r_quo;
    logic [1:0]         r_base;
    logic [WIDTH_W-1:0] r_width;
    logic               r_zero_fill;
    logic               r_sign_en;
    logic               r_sign_minus;
    logic [3:0]         r_dig [DIG_N];
    logic [ND_W-1:0]    r_nd;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [WIDTH_W-1:0] r_fill;
    logic               r_valid;
    logic [7:0]         r_char;
    logic               r_last;

    logic [63:0]        prod;
    logic [VAL_W-1:0]   quo;
    logic [VAL_W-1:0]   quo_x10;
    logic [VAL_W-1:0]   diff;
    logic [3:0]         rem;
    logic [WIDTH_W-1:0] nd_ext;
    logic [WIDTH_W-1:0] width_sat;
    logic [7:0]         n_char;

    // Reciprocal product for the decimal divide
    assign prod = {32'd0, 32'(r_val)} * {32'd0, RECIP_10};

    // Split off one digit in the chosen base
    always_comb begin
        quo_x10 = '0;
        diff    = '0;
        case (r_base)
            BASE_DEC: begin
                quo     = r_quo;
                quo_x10 = (r_quo << 3) + (r_quo << 1);
                diff    = r_val - quo_x10;
                rem     = diff[3:0];
            end
            BASE_BIN: begin
                quo = r_val >> 1;
                rem = {3'd0, r_val[0]};
            end
            default: begin
                quo = r_val >> 4;
                rem = r_val[3:0];
            end
        endcase
    end

    assign nd_ext    = WIDTH_W'(r_nd);
    assign width_sat = (i_min_width > WIDTH_W'(MAX_FIELD_WIDTH))
                     ? WIDTH_W'(MAX_FIELD_WIDTH) : i_min_width;

    // Pick the character for this beat
    always_comb begin
        case (i_cmd.sel)
            CH_FILL:  n_char = r_zero_fill ? ASCII_ZERO : ASCII_SPACE;
            CH_SIGN:  n_char = r_sign_minus ? ASCII_MINUS : ASCII_PLUS;
            CH_DIGIT: n_char = digit_char(r_dig[r_rd_idx]);
            default:  n_char = ASCII_SPACE;
        endcase
    end

    // Load format, iterate digits, count down fill and read index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val        <= i_number[VAL_W-1:0];
            r_base       <= i_base_select;
            r_width      <= width_sat;
            r_zero_fill  <= i_zero_fill;
            r_sign_en    <= i_sign_mode[SIGN_MINUS_BIT] | i_sign_mode[SIGN_PLUS_BIT];
            r_sign_minus <= i_sign_mode[SIGN_MINUS_BIT];
            r_nd         <= '0;
        end
        if (i_cmd.mul) begin
            r_quo <= VAL_W'(prod[63:RECIP_SHIFT]);
        end
        if (i_cmd.step) begin
            r_dig[r_nd[IDX_W-1:0]] <= rem;
            r_nd                   <= r_nd + 1'b1;
            r_val                  <= quo;
        end
        if (i_cmd.prep) begin
            r_fill   <= (r_width > nd_ext) ? (r_width - nd_ext) : '0;
            r_rd_idx <= IDX_W'(r_nd - 1'b1);
        end
        if (i_cmd.emit && i_cmd.sel == CH_FILL) begin
            r_fill <= r_fill - 1'b1;
        end
        if (i_cmd.emit && i_cmd.sel == CH_DIGIT) begin
            r_rd_idx <= r_rd_idx - 1'b1;
        end
    end

    // Output register: fill on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_char <= n_char;
            r_last <= (i_cmd.sel == CH_DIGIT) && (r_rd_idx == '0);
        end
    end

    assign o_out_valid = r_valid;
    assign o_character = r_char;
    assign o_last_char = r_last;

    assign o_stat.in_is_dec = (i_base_select == BASE_DEC);
    assign o_stat.is_dec    = (r_base == BASE_DEC);
    assign o_stat.quo_zero  = (quo == '0);
    assign o_stat.fill_done = (r_fill == '0);
    assign o_stat.has_sign  = r_sign_en;
    assign o_stat.idx_zero  = (r_rd_idx == '0);
    assign o_stat.out_free  = !r_valid || i_out_ready;

endmodule

`default_nettype wire

FILE: hdl/itaf_checker.sv
// Port-level checker for the integer to ASCII formatter, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module itaf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_character,
    input wire logic       i_last_char
);
    import itaf_pkg::*;

    // Take no new number right after one is accepted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted number");

    // Come out of reset with no pending beat
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // Emit only fill, sign or digit characters
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_character >= ASCII_ZERO && i_character <= 8'h39) ||
            (i_character >= ASCII_LOWER_A && i_character <= 8'h66) ||
            i_character == ASCII_SPACE || i_character == ASCII_MINUS ||
            i_character == ASCII_PLUS)
        else $error("character outside the output set");

    // Hold a stalled beat
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_character) && $stable(i_last_char))
        else $error("stalled output beat changed");

endmodule

bind integer_to_ascii_formatter_unit itaf_checker u_itaf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_character (o_out.character),
    .i_last_char (o_out.last_char)
);

`default_nettype wire

FILE: dv/integer_to_ascii_formatter_unit_tb.sv
// Self-checking testbench for the integer to ASCII formatter: directed table, random formats.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_unit_tb;
    import itaf_pkg::*;

    // Format codes not named by the package
    localparam logic [1:0] BASE_UNUSED = 2'd3;
    localparam logic [1:0] SIGN_NONE   = 2'd0;
    localparam logic [1:0] SIGN_PLUS   = 2'd1;
    localparam logic [1:0] SIGN_MINUS  = 2'd2;
    localparam logic [1:0] SIGN_BOTH   = 2'd3;
    localparam logic       PAD_SPACE   = 1'b0;
    localparam logic       PAD_ZERO    = 1'b1;

    localparam int TEXT_MAX      = 64;
    localparam int RANDOM_ITEMS  = 300;
    localparam int HOLD_START    = 4000;
    localparam int HOLD_CYCLES   = 500;
    localparam int QUIET_START   = 6000;
    localparam int QUIET_CYCLES  = 2000;
    localparam int DRAIN_CYCLES  = 150;

    typedef struct packed {
        logic [NUM_W-1:0]   number;
        logic [WIDTH_W-1:0] min_width;
        logic [1:0]         base_select;
        logic               zero_fill;
        logic [1:0]         sign_mode;
    } t_num_fmt;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    // Directed row: format plus typed text (zero means use the predictor)
    typedef struct packed {
        t_num_fmt                  fmt;
        logic [TEXT_MAX*8-1:0]     text;
    } t_dir_row;

    localparam int N_DIR = 22;

    t_dir_row directed_rows [N_DIR] = '{
        '{'{32'd0, 6'd0, BASE_HEX, PAD_SPACE, SIGN_NONE}, "0"},
        '{'{32'd0, 6'd0, BASE_DEC, PAD_SPACE, SIGN_NONE}, "0"},
        '{'{32'd0, 6'd0, BASE_BIN, PAD_ZERO, SIGN_NONE}, "0"},
        '{'{32'hFFFF_FFFF, 6'd0, BASE_HEX, PAD_SPACE, SIGN_NONE}, "ffffffff"},
        '{'{32'hFFFF_FFFF, 6'd0, BASE_DEC, PAD_SPACE, SIGN_NONE}, "4294967295"},
        '{'{32'hFFFF_FFFF, 6'd0, BASE_BIN, PAD_SPACE, SIGN_NONE},
          "11111111111111111111111111111111"},
        '{'{32'hDEAD_BEEF, 6'd12, BASE_HEX, PAD_ZERO, SIGN_PLUS}, "0000+deadbeef"},
        '{'{32'd255, 6'd6, BASE_DEC, PAD_SPACE, SIGN_MINUS}, "   -255"},
        '{'{32'd5, 6'd8, BASE_BIN, PAD_ZERO, SIGN_NONE}, "00000101"},
        '{'{32'h0000_0ABC, 6'd0, BASE_UNUSED, PAD_SPACE, SIGN_NONE}, "abc"},
        '{'{32'd7, 6'd0, BASE_DEC, PAD_SPACE, SIGN_BOTH}, "-7"},
        '{'{32'd0, 6'd5, BASE_DEC, PAD_SPACE, SIGN_PLUS}, "    +0"},
        '{'{32'd1, 6'd1, BASE_DEC, PAD_ZERO, SIGN_NONE}, "1"},
        '{'{32'd15, 6'd0, BASE_HEX, PAD_SPACE, SIGN_NONE}, "f"},
        '{'{32'd10, 6'd0, BASE_DEC, PAD_SPACE, SIGN_NONE}, "10"},
        '{'{32'd1_000_000_000, 6'd10, BASE_DEC, PAD_ZERO, SIGN_NONE}, "1000000000"},
        '{'{32'hFFFF_FFFF, 6'd63, BASE_BIN, PAD_ZERO, SIGN_PLUS}, {TEXT_MAX*8{1'b0}}},
        '{'{32'd0, 6'd63, BASE_HEX, PAD_SPACE, SIGN_MINUS}, {TEXT_MAX*8{1'b0}}},
        '{'{32'h8000_0000, 6'd40, BASE_BIN, PAD_SPACE, SIGN_BOTH}, {TEXT_MAX*8{1'b0}}},
        '{'{32'h1234_5678, 6'd20, BASE_DEC, PAD_SPACE, SIGN_PLUS}, {TEXT_MAX*8{1'b0}}},
        '{'{32'hAAAA_AAAA, 6'd33, BASE_BIN, PAD_ZERO, SIGN_MINUS}, {TEXT_MAX*8{1'b0}}},
        '{'{32'h5555_5555, 6'd63, BASE_UNUSED, PAD_ZERO, SIGN_NONE}, {TEXT_MAX*8{1'b0}}}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    itaf_in_if  num_ch ();
    itaf_out_if char_ch ();

    t_text_char expected_chars [$];
    int         mismatch_count = 0;
    int         rx_cycle = 0;

    integer_to_ascii_formatter_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (num_ch),
        .o_out   (char_ch)
    );

    always #5 clk = ~clk;

    // Mark the newest expected character as the end of its number
    function automatic void close_text();
        expected_chars[expected_chars.size()-1].last = 1'b1;
    endfunction

    // Build the expected text of one number: fill, sign, digits msb first
    function automatic void format_number(input t_num_fmt f);
        logic [CHAR_W-1:0] digit_codes [$];
        logic [CHAR_W-1:0] line [$];
        logic [NUM_W-1:0]  rest;
        logic [NUM_W-1:0]  radix;
        logic [NUM_W-1:0]  d;
        int                field;
        rest  = f.number;
        field = int'(f.min_width);
        if (f.base_select == BASE_BIN) begin
            radix = 32'd2;
        end else if (f.base_select == BASE_DEC) begin
            radix = 32'd10;
        end else begin
            radix = 32'd16;
        end
        // extract digits lsb first, zero still gives one digit
        do begin
            d = rest % radix;
            if (d < 32'd10) begin
                digit_codes.push_front(ASCII_ZERO + CHAR_W'(d));
            end else begin
                digit_codes.push_front(ASCII_LOWER_A + CHAR_W'(d - 32'd10));
            end
            rest = rest / radix;
        end while (rest != 0);
        for (int k = digit_codes.size(); k < field; k++) begin
            line.push_back(f.zero_fill ? ASCII_ZERO : ASCII_SPACE);
        end
        if (f.sign_mode[SIGN_MINUS_BIT]) begin
            line.push_back(ASCII_MINUS);
        end else if (f.sign_mode[SIGN_PLUS_BIT]) begin
            line.push_back(ASCII_PLUS);
        end
        foreach (digit_codes[k]) begin
            line.push_back(digit_codes[k]);
        end
        // truncate overlong text
        while (line.size() > TEXT_MAX) begin
            void'(line.pop_back());
        end
        foreach (line[k]) begin
            expected_chars.push_back('{line[k], 1'b0});
        end
        close_text();
    endfunction

    // Queue a typed text, first character in the highest nonzero byte
    function automatic void expect_typed(input logic [TEXT_MAX*8-1:0] t);
        for (int i = TEXT_MAX - 1; i >= 0; i--) begin
            if (t[i*8 +: 8] != 8'h00) begin
                expected_chars.push_back('{t[i*8 +: 8], 1'b0});
            end
        end
        close_text();
    endfunction

    // Mostly small widths; values small, medium, full-range or near the maximum
    function automatic t_num_fmt random_format();
        t_num_fmt f;
        case ($urandom_range(3))
            0: f.number = $urandom_range(15);
            1: f.number = $urandom_range(99999);
            2: f.number = $urandom;
            default: f.number = 32'hFFFF_FFFF - $urandom_range(255);
        endcase
        f.min_width   = ($urandom_range(9) == 0) ? WIDTH_W'($urandom_range(63))
                                                 : WIDTH_W'($urandom_range(12));
        f.base_select = ($urandom_range(19) == 0) ? BASE_UNUSED : 2'($urandom_range(2));
        f.zero_fill   = 1'($urandom_range(1));
        f.sign_mode   = 2'($urandom_range(3));
        return f;
    endfunction

    // Offer one number beat, optionally after a short gap; predict on accept
    task automatic offer_number(input t_num_fmt f, input logic [TEXT_MAX*8-1:0] typed,
                                input bit no_gaps);
        if (!no_gaps && $urandom_range(99) < 6) begin
            num_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 6) @(posedge clk);
        end
        num_ch.valid       <= 1'b1;
        num_ch.number      <= f.number;
        num_ch.min_width   <= f.min_width;
        num_ch.base_select <= f.base_select;
        num_ch.zero_fill   <= f.zero_fill;
        num_ch.sign_mode   <= f.sign_mode;
        @(posedge clk);
        while (!num_ch.ready) @(posedge clk);
        if (typed != '0) begin
            expect_typed(typed);
        end else begin
            format_number(f);
        end
    endtask

    // Drive the character receiver: long hold-off once, a quiet stretch, else ~6% stalls
    initial begin
        char_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES) begin
                char_ch.ready <= 1'b0;
            end else if (rx_cycle >= QUIET_START && rx_cycle < QUIET_START + QUIET_CYCLES) begin
                char_ch.ready <= 1'b1;
            end else begin
                char_ch.ready <= ($urandom_range(99) >= 6);
            end
        end
    end

    // Compare every accepted character beat with the oldest expectation
    always @(posedge clk) begin
        t_text_char want;
        if (rst_n && char_ch.valid && char_ch.ready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character, expected none, got %h last %b",
                         $time, char_ch.character, char_ch.last_char);
                mismatch_count++;
            end else begin
                want = expected_chars.pop_front();
                if (char_ch.character !== want.code) begin
                    $display("%0t: character mismatch, expected %h got %h",
                             $time, want.code, char_ch.character);
                    mismatch_count++;
                end
                if (char_ch.last_char !== want.last) begin
                    $display("%0t: last_char mismatch, expected %b got %b",
                             $time, want.last, char_ch.last_char);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, random formats, drain
    initial begin
        num_ch.valid       = 1'b0;
        num_ch.number      = '0;
        num_ch.min_width   = '0;
        num_ch.base_select = BASE_HEX;
        num_ch.zero_fill   = PAD_SPACE;
        num_ch.sign_mode   = SIGN_NONE;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            offer_number(directed_rows[i].fmt, directed_rows[i].text, 1'b0);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            offer_number(random_format(), '0, (n >= 120 && n < 180));
        end
        num_ch.valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: integer_to_ascii_formatter_unit.f
hdl/itaf_pkg.sv
hdl/itaf_if.sv
hdl/itaf_ctrl.sv
hdl/itaf_dp.sv
hdl/integer_to_ascii_formatter_unit.sv
hdl/itaf_checker.sv
dv/integer_to_ascii_formatter_unit_tb.sv
